@@ sv/assert_macros.svh @@
// Assertion helpers used by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/erpd_pkg.sv @@
// ---------------------------------------------------------------------------
// erpd_pkg
// Types and constants of the echo ranging presence detector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package erpd_pkg;

  // Width of the echo tick counter (8 to 32).
  localparam int WIDTH_BITS = 16;
  // Comparisons run at the wider of counter and limit registers.
  localparam int LIMIT_BITS = 16;
  localparam int RUNLIM_BITS = 8;
  localparam int CMP_BITS = (WIDTH_BITS > LIMIT_BITS) ? WIDTH_BITS : LIMIT_BITS;
  localparam int PULSE_BITS = 16;
  localparam int RUN_BITS = 9;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [WIDTH_BITS-1:0] CNT_MAX = {WIDTH_BITS{1'b1}};
  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  localparam logic [LIMIT_BITS-1:0] MIN_WIDTH_RST = LIMIT_BITS'(4);
  localparam logic [LIMIT_BITS-1:0] MAX_WIDTH_RST = LIMIT_BITS'(600);
  localparam logic [RUNLIM_BITS-1:0] MISS_LIMIT_RST = RUNLIM_BITS'(50);
  localparam logic [RUNLIM_BITS-1:0] HIT_LIMIT_RST = RUNLIM_BITS'(2);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_WIDTH  = 2'd0,
    REG_MAX_WIDTH  = 2'd1,
    REG_MISS_LIMIT = 2'd2,
    REG_HIT_LIMIT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_REQ  = 2'd1,
    PH_SENT = 2'd2
  } phase_t;

endpackage

`default_nettype wire

@@ sv/erpd_in_if.sv @@
// ---------------------------------------------------------------------------
// erpd_in_if
// Tick channel: sampled echo level and trigger request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface erpd_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  logic start_request;

  modport source (output valid, output echo_level, output start_request, input ready);
  modport sink (input valid, input echo_level, input start_request, output ready);
endinterface

`default_nettype wire

@@ sv/erpd_out_if.sv @@
// ---------------------------------------------------------------------------
// erpd_out_if
// Result channel: trigger drive, phase, latched width and presence events.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface erpd_out_if;
  import erpd_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  trigger_level;
  logic [1:0]            trigger_phase;
  logic                  width_valid;
  logic [PULSE_BITS-1:0] pulse_width;
  logic                  presence_lost;
  logic                  presence_found;

  modport source (output valid, output trigger_level, output trigger_phase,
                  output width_valid, output pulse_width, output presence_lost,
                  output presence_found, input ready);
  modport sink (input valid, input trigger_level, input trigger_phase,
                input width_valid, input pulse_width, input presence_lost,
                input presence_found, output ready);
endinterface

`default_nettype wire

@@ sv/echo_ranging_presence_detector.sv @@
// ---------------------------------------------------------------------------
// echo_ranging_presence_detector
// Trigger pulse generation, echo width measurement and hit/miss run tracking.
// ---------------------------------------------------------------------------
// Channel  | Dir | Handshake     | Payload
// in_ch    | in  | valid/ready   | echo_level, start_request
// out_ch   | out | valid/ready   | trigger_level, trigger_phase, width_valid,
//          |     |               | pulse_width, presence_lost, presence_found
// cfg      | in  | cfg_we        | cfg_index, cfg_data
//
// One tick per cycle while in_ch.ready is high; each result appears in the cycle after its transaction.
// The state update is three saturating increments, two width compares and two run
// limit compares between the state registers and the result register.
// in_ch.ready is high whenever the result register is empty or being taken.
// Synchronous active-high reset; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module echo_ranging_presence_detector (
  input  wire                                 clk,
  input  wire                                 rst,
  erpd_in_if.sink                             in_ch,
  erpd_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire [erpd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire [erpd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import erpd_pkg::*;

  // Configuration registers
  logic [LIMIT_BITS-1:0]  min_width;
  logic [LIMIT_BITS-1:0]  max_width;
  logic [RUNLIM_BITS-1:0] miss_limit;
  logic [RUNLIM_BITS-1:0] hit_limit;

  // Tick state
  phase_t                 phase, phase_next;
  logic [WIDTH_BITS-1:0]  high_ticks, high_ticks_next;
  logic [WIDTH_BITS-1:0]  latched_width, latched_width_next;
  logic                   prev_echo;
  logic [RUN_BITS-1:0]    miss_run, miss_run_next;
  logic [RUN_BITS-1:0]    hit_run, hit_run_next;

  // Result register
  logic                   out_valid;
  logic                   trig_next, valid_next, lost_next, found_next;

  logic                   accept;
  logic                   fall;
  logic                   is_hit;
  logic [CMP_BITS-1:0]    ticks_ext;
  logic [CMP_BITS-1:0]    lw_ext;
  logic [RUN_BITS-1:0]    miss_inc, hit_inc;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign fall        = !in_ch.echo_level && prev_echo;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width  <= MIN_WIDTH_RST;
      max_width  <= MAX_WIDTH_RST;
      miss_limit <= MISS_LIMIT_RST;
      hit_limit  <= HIT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_WIDTH:  min_width  <= cfg_data[LIMIT_BITS-1:0];
        REG_MAX_WIDTH:  max_width  <= cfg_data[LIMIT_BITS-1:0];
        REG_MISS_LIMIT: miss_limit <= cfg_data[RUNLIM_BITS-1:0];
        REG_HIT_LIMIT:  hit_limit  <= cfg_data[RUNLIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Trigger phase: one-tick pulse on the request tick, then wait for the falling echo edge.
  always_comb begin
    phase_next = phase;
    if (in_ch.start_request || phase == PH_REQ) begin
      phase_next = PH_SENT;
    end
    if (fall) begin
      phase_next = PH_IDLE;
    end
  end

  always_comb begin
    trig_next = in_ch.start_request || (phase == PH_REQ);
  end

  // Echo width and run tracking
  always_comb begin
    ticks_ext          = CMP_BITS'(high_ticks);
    is_hit             = (ticks_ext > CMP_BITS'(min_width)) &&
                         (ticks_ext < CMP_BITS'(max_width));
    miss_inc           = (miss_run != RUN_MAX) ? miss_run + 1'b1 : miss_run;
    hit_inc            = (hit_run != RUN_MAX) ? hit_run + 1'b1 : hit_run;
    high_ticks_next    = high_ticks;
    latched_width_next = latched_width;
    miss_run_next      = miss_run;
    hit_run_next       = hit_run;
    valid_next         = 1'b0;
    lost_next          = 1'b0;
    found_next         = 1'b0;
    if (in_ch.echo_level) begin
      if (high_ticks != CNT_MAX) begin
        high_ticks_next = high_ticks + 1'b1;
      end
    end else if (prev_echo) begin
      latched_width_next = high_ticks;
      high_ticks_next    = '0;
      valid_next         = 1'b1;
      if (is_hit) begin
        miss_run_next = '0;
        hit_run_next  = hit_inc;
      end else begin
        hit_run_next  = '0;
        miss_run_next = miss_inc;
      end
      if (miss_run_next > RUN_BITS'(miss_limit)) begin
        lost_next     = 1'b1;
        miss_run_next = '0;
      end
      if (hit_run_next > RUN_BITS'(hit_limit)) begin
        found_next   = 1'b1;
        hit_run_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      high_ticks    <= '0;
      latched_width <= '0;
      prev_echo     <= 1'b0;
      miss_run      <= '0;
      hit_run       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        high_ticks    <= high_ticks_next;
        latched_width <= latched_width_next;
        prev_echo     <= in_ch.echo_level;
        miss_run      <= miss_run_next;
        hit_run       <= hit_run_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded on each transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.trigger_level  <= trig_next;
      out_ch.trigger_phase  <= phase_next;
      out_ch.width_valid    <= valid_next;
      out_ch.pulse_width    <= lw_ext[PULSE_BITS-1:0];
      out_ch.presence_lost  <= lost_next;
      out_ch.presence_found <= found_next;
    end
  end

  assign lw_ext       = CMP_BITS'(latched_width_next);
  assign out_ch.valid = out_valid;

  `ASSERT_IMPL(a_event_on_edge, clk, rst,
               out_valid && (out_ch.presence_lost || out_ch.presence_found),
               out_ch.width_valid)
  `ASSERT_IMPL(a_runs_exclusive, clk, rst, 1'b1, (hit_run == '0) || (miss_run == '0))
  `ASSERT_NEXT(a_fall_idles, clk, rst, accept && fall, phase == PH_IDLE)
  `ASSERT_NEXT(a_result_held, clk, rst, accept, out_valid)

endmodule

`default_nettype wire
